// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("assertion failed");

// Checked on every rising edge of clk, reset cycles included.
`define ASSERT_CLK_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
  else $error("assertion failed");

`endif

// ===== hw/rtl/mqtt_rd_pkg.sv =====
package mqtt_rd_pkg;

  localparam int LEN_W  = 28;
  localparam int KIND_W = 4;
  localparam int BYTE_W = 8;

  localparam int LENGTH_FIELD_BYTES_DEF = 4;

  localparam logic [LEN_W-1:0]  MAX_BODY_LEN_RESET = 28'd512;
  localparam logic [KIND_W-1:0] KIND_CONNACK       = 4'h2;
  localparam logic [LEN_W-1:0]  CONNACK_LEN        = 28'd2;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  typedef struct packed {
    logic              packet_end;
    logic [KIND_W-1:0] packet_kind;
    logic [LEN_W-1:0]  body_length;
    logic              discarded;
    logic              connack_accepted;
    logic              drop_connection;
    logic              session_up;
  } result_t;

endpackage

// ===== hw/rtl/mqtt_receive_deframer_unit.sv =====
// Channel  Handshake             Payload
// input    in_valid / in_stall   cmd, rx_byte
// output   out_valid / out_stall packet_end .. session_up
// config   cfg_valid / cfg_ready cfg_data (max_body_len)
//
// One item per cycle while in_stall is low; each result is registered.
// The rate is set by the single pass through the header, length and body
// logic between the parser state registers and the output register.
// rst is synchronous and active high; it clears the parser and sets the
// limit to 512. A two-entry output buffer lets an item in while one result
// waits; in_stall rises only once both entries are full.
`include "assert_macros.svh"

module mqtt_receive_deframer_unit
  import mqtt_rd_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              packet_end,
  output logic [KIND_W-1:0] packet_kind,
  output logic [LEN_W-1:0]  body_length,
  output logic              discarded,
  output logic              connack_accepted,
  output logic              drop_connection,
  output logic              session_up,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  phase_t            phase, phase_next;
  logic [KIND_W-1:0] kind_reg, kind_reg_next;
  logic [LEN_W-1:0]  length_accum, length_accum_next;
  logic [2:0]        length_bytes_seen, length_bytes_seen_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [1:0]        body_position, body_position_next;
  logic              code_ok, code_ok_next;
  logic              session_open, session_open_next;
  logic              skip_flag, skip_flag_next;
  logic [LEN_W-1:0]  max_body_len;

  logic              in_accept;
  logic              out_take;
  logic [LEN_W-1:0]  addend;
  logic [LEN_W-1:0]  accum_sum;
  logic [LEN_W-1:0]  left_dec;
  logic [2:0]        seen_inc;
  logic              finish;
  logic              accepted;
  logic              drop;
  result_t           res;

  result_t           out_q;
  result_t           skid_q;
  logic              skid_valid;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // The seven-bit group lands at its place in the length; groups never overlap.
  always_comb begin
    case (length_bytes_seen[1:0])
      2'd0:    addend = {21'd0, rx_byte[6:0]};
      2'd1:    addend = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    addend = {7'd0, rx_byte[6:0], 14'd0};
      2'd3:    addend = {rx_byte[6:0], 21'd0};
      default: addend = '0;
    endcase
  end

  assign accum_sum = length_accum + addend;
  assign seen_inc  = length_bytes_seen + 3'd1;
  assign left_dec  = bytes_left - LEN_W'(1);

  always_comb begin
    phase_next             = phase;
    kind_reg_next          = kind_reg;
    length_accum_next      = length_accum;
    length_bytes_seen_next = length_bytes_seen;
    bytes_left_next        = bytes_left;
    body_position_next     = body_position;
    code_ok_next           = code_ok;
    session_open_next      = session_open;
    skip_flag_next         = skip_flag;
    finish                 = 1'b0;
    accepted               = 1'b0;
    drop                   = 1'b0;

    case (phase)
      PH_HEADER: begin
        kind_reg_next          = rx_byte[7:4];
        length_accum_next      = '0;
        length_bytes_seen_next = '0;
        bytes_left_next        = '0;
        body_position_next     = '0;
        code_ok_next           = 1'b0;
        skip_flag_next         = 1'b0;
        phase_next             = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_accum_next      = accum_sum;
        length_bytes_seen_next = seen_inc;
        if (!rx_byte[7] || seen_inc >= 3'(LENGTH_FIELD_BYTES)) begin
          skip_flag_next  = accum_sum > max_body_len;
          bytes_left_next = accum_sum;
          if (accum_sum == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (body_position == 2'd1) begin
          code_ok_next = rx_byte == '0;
        end
        if (body_position != 2'd2) begin
          body_position_next = body_position + 2'd1;
        end
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    if (finish) begin
      phase_next = PH_HEADER;
      if (kind_reg_next == KIND_CONNACK && !skip_flag_next) begin
        if (!session_open && length_accum_next == CONNACK_LEN && code_ok_next) begin
          session_open_next = 1'b1;
          accepted          = 1'b1;
        end else begin
          drop = 1'b1;
        end
      end
    end

    res.packet_end       = finish;
    res.packet_kind      = kind_reg_next;
    res.body_length      = length_accum_next;
    res.discarded        = skip_flag_next;
    res.connack_accepted = accepted;
    res.drop_connection  = drop;
    res.session_up       = session_open_next && !drop;

    // A drop or a reset command leaves the parser as after reset.
    if (drop || cmd == CMD_RESET) begin
      phase_next             = PH_HEADER;
      kind_reg_next          = '0;
      length_accum_next      = '0;
      length_bytes_seen_next = '0;
      bytes_left_next        = '0;
      body_position_next     = '0;
      code_ok_next           = 1'b0;
      session_open_next      = 1'b0;
      skip_flag_next         = 1'b0;
    end
    if (cmd == CMD_RESET) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      kind_reg          <= '0;
      length_accum      <= '0;
      length_bytes_seen <= '0;
      bytes_left        <= '0;
      body_position     <= '0;
      code_ok           <= 1'b0;
      session_open      <= 1'b0;
      skip_flag         <= 1'b0;
      max_body_len      <= MAX_BODY_LEN_RESET;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_body_len <= cfg_data;
      end
      if (in_accept) begin
        phase             <= phase_next;
        kind_reg          <= kind_reg_next;
        length_accum      <= length_accum_next;
        length_bytes_seen <= length_bytes_seen_next;
        bytes_left        <= bytes_left_next;
        body_position     <= body_position_next;
        code_ok           <= code_ok_next;
        session_open      <= session_open_next;
        skip_flag         <= skip_flag_next;
      end
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= res;
      end
    end else if (in_accept) begin
      skid_q <= res;
    end
  end

  assign packet_end       = out_q.packet_end;
  assign packet_kind      = out_q.packet_kind;
  assign body_length      = out_q.body_length;
  assign discarded        = out_q.discarded;
  assign connack_accepted = out_q.connack_accepted;
  assign drop_connection  = out_q.drop_connection;
  assign session_up       = out_q.session_up;

  `ASSERT_CLK_ALWAYS(a_skid_needs_out, skid_valid |-> out_valid)
  `ASSERT_CLK(a_drop_closes, out_valid && drop_connection |-> !session_up && !connack_accepted)
  `ASSERT_CLK(a_cmd_clears, in_accept && cmd == CMD_RESET |=> phase == PH_HEADER && !session_open)
  `ASSERT_CLK(a_open_by_accept, $rose(session_open) |-> $past(in_accept) && $past(accepted))

endmodule
